// File: src/psx_pkg.sv
// ----------------------------------------------------------------------------
// psx_pkg: shared types and constants of the printable string extractor
// Queue entry layout, front-to-queue write command, register indexes and
// the printable character range.
// ----------------------------------------------------------------------------
package psx_pkg;

    localparam int MAX_MIN_LEN_DEF = 16;

    localparam int BYTE_W     = 8;
    localparam int CHAR_W     = 7;
    localparam int MIN_LEN_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 5'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE = 1'b1;

    // Printable range is CHAR_LO up to, not including, CHAR_END
    localparam logic [BYTE_W-1:0] CHAR_LO  = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_END = 8'h7F;

    // One queue entry: a character, an end marker, or a character with an
    // end marker behind it. last flags the final result of its input item.
    typedef struct packed {
        logic              has_char;
        logic [CHAR_W-1:0] ch;
        logic              marker;
        logic              last;
    } psx_entry_t;

    // Write command from the front to the queue
    typedef struct packed {
        logic       en;
        logic       commit;
        logic       rewind;
        psx_entry_t entry;
    } psx_wr_t;

    function automatic logic is_printable(input logic [BYTE_W-1:0] b);
        return (b >= CHAR_LO) && (b < CHAR_END);
    endfunction

endpackage

// File: src/psx_front.sv
// ----------------------------------------------------------------------------
// psx_front: byte classifier and run tracker
// Holds the configuration, pairs bytes in wide mode, counts held characters
// and issues write, commit and rewind commands to the queue.
// ----------------------------------------------------------------------------
module psx_front #(
    parameter int MAX_MIN_LEN = psx_pkg::MAX_MIN_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [psx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psx_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                accept,
    input  logic [psx_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                blob_end,
    output psx_pkg::psx_wr_t                    wr
);
    import psx_pkg::*;

    localparam int CNT_W = $clog2(MAX_MIN_LEN);
    localparam int CMP_W = ((CNT_W > MIN_LEN_W) ? CNT_W : MIN_LEN_W) + 1;

    logic [MIN_LEN_W-1:0] min_len_reg;
    logic                 wide_reg;
    logic                 pair_phase_reg, pair_phase_next;
    logic [BYTE_W-1:0]    low_byte_reg, low_byte_next;
    logic [CNT_W-1:0]     run_cnt_reg, run_cnt_next;
    logic                 released_reg, released_next;

    logic                 got_char;
    logic                 got_break;
    logic [CHAR_W-1:0]    ch;
    logic [CMP_W-1:0]     need;
    logic                 reaches;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RESET;
            wide_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_LEN:   min_len_reg <= cfg_data;
                REG_WIDE_MODE: wide_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Classify the byte (or completed pair)
    always_comb
    begin
        got_char  = 1'b0;
        got_break = 1'b0;
        ch        = data_byte[CHAR_W-1:0];
        if (!wide_reg)
        begin
            got_char  = is_printable(data_byte);
            got_break = !got_char;
        end
        else if (pair_phase_reg)
        begin
            got_char  = (data_byte == '0) && is_printable(low_byte_reg);
            got_break = !got_char;
            ch        = low_byte_reg[CHAR_W-1:0];
        end
    end

    // Clamp min_length to 1..MAX_MIN_LEN
    always_comb
    begin
        if (min_len_reg == '0)
            need = CMP_W'(1);
        else if (CMP_W'(min_len_reg) > CMP_W'(MAX_MIN_LEN))
            need = CMP_W'(MAX_MIN_LEN);
        else
            need = CMP_W'(min_len_reg);
    end

    assign reaches = (CMP_W'(run_cnt_reg) + CMP_W'(1)) >= need;

    always_comb
    begin
        wr              = '0;
        pair_phase_next = pair_phase_reg;
        low_byte_next   = low_byte_reg;
        run_cnt_next    = run_cnt_reg;
        released_next   = released_reg;
        if (accept)
        begin
            // Advance pairing
            if (wide_reg && !pair_phase_reg)
            begin
                low_byte_next   = data_byte;
                pair_phase_next = 1'b1;
            end
            else
            begin
                pair_phase_next = 1'b0;
            end
            if (blob_end)
                pair_phase_next = 1'b0;

            if (got_char)
            begin
                if (released_reg || reaches)
                begin
                    // Pass through, or release the held run along with it
                    wr.en     = 1'b1;
                    wr.commit = 1'b1;
                    wr.entry  = '{has_char: 1'b1, ch: ch, marker: blob_end, last: 1'b1};
                    released_next = !blob_end;
                    run_cnt_next  = '0;
                end
                else if (blob_end)
                begin
                    // Drop the short run
                    wr.rewind     = 1'b1;
                    run_cnt_next  = '0;
                    released_next = 1'b0;
                end
                else
                begin
                    // Hold the character in the queue, uncommitted
                    wr.en        = 1'b1;
                    wr.entry     = '{has_char: 1'b1, ch: ch, marker: 1'b0, last: 1'b0};
                    run_cnt_next = run_cnt_reg + CNT_W'(1);
                end
            end
            else if (got_break || blob_end)
            begin
                if (released_reg)
                begin
                    wr.en     = 1'b1;
                    wr.commit = 1'b1;
                    wr.entry  = '{has_char: 1'b0, ch: '0, marker: 1'b1, last: 1'b1};
                end
                else
                begin
                    wr.rewind = 1'b1;
                end
                run_cnt_next  = '0;
                released_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_phase_reg <= 1'b0;
            low_byte_reg   <= '0;
            run_cnt_reg    <= '0;
            released_reg   <= 1'b0;
        end
        else
        begin
            pair_phase_reg <= pair_phase_next;
            low_byte_reg   <= low_byte_next;
            run_cnt_reg    <= run_cnt_next;
            released_reg   <= released_next;
        end
    end

endmodule

// File: src/psx_queue.sv
// ----------------------------------------------------------------------------
// psx_queue: entry queue with uncommitted tail
// Held characters sit past the commit pointer until released; a rewind
// drops them. Only committed entries are read.
// ----------------------------------------------------------------------------
module psx_queue #(
    parameter int MAX_MIN_LEN = psx_pkg::MAX_MIN_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psx_pkg::psx_wr_t      wr,
    output logic                  full,
    output logic                  avail,
    input  logic                  rd_en,
    output psx_pkg::psx_entry_t   rd_data
);
    import psx_pkg::*;

    localparam int AW    = $clog2(2 * MAX_MIN_LEN);
    localparam int DEPTH = 2 ** AW;
    localparam int PW    = AW + 1;

    psx_entry_t    mem [DEPTH];
    psx_entry_t    rd_data_reg;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] commit_ptr_reg, commit_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] used;

    assign used    = wr_ptr_reg - rd_ptr_reg;
    assign full    = (used == PW'(DEPTH));
    assign avail   = (commit_ptr_reg != rd_ptr_reg);
    assign rd_data = rd_data_reg;

    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg;
        commit_ptr_next = commit_ptr_reg;
        if (wr.rewind)
            wr_ptr_next = commit_ptr_reg;
        else if (wr.en)
            wr_ptr_next = wr_ptr_reg + PW'(1);
        if (wr.en && wr.commit)
            commit_ptr_next = wr_ptr_reg + PW'(1);
        rd_ptr_next = rd_en ? (rd_ptr_reg + PW'(1)) : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            commit_ptr_reg <= '0;
            rd_ptr_reg     <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            commit_ptr_reg <= commit_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr_ptr_reg[AW-1:0]] <= wr.entry;
        if (rd_en)
            rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
    end

endmodule

// File: src/psx_back.sv
// ----------------------------------------------------------------------------
// psx_back: result issue stage
// Holds the head entry and expands it into one or two result items.
// ----------------------------------------------------------------------------
module psx_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          avail,
    output logic                          rd_en,
    input  psx_pkg::psx_entry_t           rd_data,
    input  logic                          pop,
    output logic                          empty,
    output logic [psx_pkg::CHAR_W-1:0]    out_char,
    output logic                          string_done,
    output logic                          final_of_run
);
    import psx_pkg::*;

    logic head_valid_reg, head_valid_next;
    logic char_sent_reg, char_sent_next;
    logic show_char;
    logic pop_ok;
    logic entry_done;

    assign show_char    = rd_data.has_char && !char_sent_reg;
    assign empty        = !head_valid_reg;
    assign out_char     = show_char ? rd_data.ch : '0;
    assign string_done  = !show_char;
    assign final_of_run = show_char ? (rd_data.last && !rd_data.marker) : 1'b1;

    assign pop_ok     = pop && head_valid_reg;
    assign entry_done = pop_ok && !(show_char && rd_data.marker);
    assign rd_en      = avail && (!head_valid_reg || entry_done);

    always_comb
    begin
        head_valid_next = head_valid_reg;
        char_sent_next  = char_sent_reg;
        if (rd_en)
        begin
            head_valid_next = 1'b1;
            char_sent_next  = 1'b0;
        end
        else if (entry_done)
        begin
            head_valid_next = 1'b0;
        end
        else if (pop_ok)
        begin
            // Character gone, marker still to send
            char_sent_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            char_sent_reg  <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            char_sent_reg  <= char_sent_next;
        end
    end

endmodule

// File: src/printable_string_extractor.sv
// ----------------------------------------------------------------------------
// printable_string_extractor: ASCII / UTF-16LE printable run finder
// Scans a blob byte by byte and emits the characters of every printable
// run of at least min_length characters, each run closed by an end marker.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   config   | cfg_we               | cfg_index, cfg_data
//   input    | push / full          | data_byte, blob_end
//   result   | pop / empty          | out_char, string_done, final_of_run
//
// One byte is accepted per cycle while full is low. Each byte becomes at
// most one queue entry; held characters wait in the queue uncommitted and
// are released by moving the commit pointer, then leave at one result per
// cycle while popped (a character with an end marker yields two results).
// The queue holds 2**clog2(2*MAX_MIN_LEN) entries, held ones included; full
// rises when every slot is taken. Input stalls while results are not popped,
// or when bytes that each close a run with a character and an end marker
// arrive faster than their two results leave.
// Reset clears pointers and run state at once; no clearing pass is needed.
// Results come out of the queue memory through a registered head entry.
// ----------------------------------------------------------------------------
module printable_string_extractor #(
    parameter int MAX_MIN_LEN = psx_pkg::MAX_MIN_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [psx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psx_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [psx_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            blob_end,
    output logic                            empty,
    input  logic                            pop,
    output logic [psx_pkg::CHAR_W-1:0]      out_char,
    output logic                            string_done,
    output logic                            final_of_run
);
    import psx_pkg::*;

    psx_wr_t    wr;
    psx_entry_t rd_data;
    logic       accept;
    logic       avail;
    logic       rd_en;

    // Take an item whenever the queue has room
    assign accept = push && !full;

    // Front: classify bytes, track the run, hold or release characters
    psx_front #(
        .MAX_MIN_LEN (MAX_MIN_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (data_byte),
        .blob_end  (blob_end),
        .wr        (wr)
    );

    // Queue: committed entries feed the back, uncommitted ones are held chars
    psx_queue #(
        .MAX_MIN_LEN (MAX_MIN_LEN)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .full    (full),
        .avail   (avail),
        .rd_en   (rd_en),
        .rd_data (rd_data)
    );

    // Back: expand entries into result items
    psx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .avail        (avail),
        .rd_en        (rd_en),
        .rd_data      (rd_data),
        .pop          (pop),
        .empty        (empty),
        .out_char     (out_char),
        .string_done  (string_done),
        .final_of_run (final_of_run)
    );

    // A rewind discards held characters and never coincides with a write
    a_rewind_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr.rewind |-> !wr.en)
        else $error("rewind together with queue write");

    // Commits only come with a write
    a_commit_with_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr.commit |-> wr.en)
        else $error("commit without queue write");

    // An end marker always closes the results of its item
    a_marker_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && string_done) |-> final_of_run)
        else $error("end marker not flagged final");

    // A result not taken stays on the ports
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(string_done)))
        else $error("result changed while stalled");

endmodule

// File: tb/printable_string_extractor_test.sv
// ----------------------------------------------------------------------------
// printable_string_extractor_test: self-checking bench for the string finder
// Drives byte blobs in ASCII and UTF-16LE mode through the queue-style
// ports. A predictor built into the bench computes the expected characters
// and end markers of every accepted byte. Every popped result is checked,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module printable_string_extractor_test;

    import psx_pkg::*;

    localparam int MAX_LEN      = MAX_MIN_LEN_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 6;      // pipeline is two deep; leave margin
    localparam int HOLD_CYCLES  = 150;    // long receiver hold-off
    localparam int SCRIPT_ROWS  = 32;
    localparam int NUM_PHASES   = 7;
    localparam int PRESSURE_PHASE = 2;
    localparam int PAUSE_PHASE    = 5;

    // Per-phase register values and idle/stall percentages
    localparam int PHASE_MIN   [NUM_PHASES] = '{6, 1, 1, 31, 16, 0, 4};
    localparam int PHASE_WIDE  [NUM_PHASES] = '{0, 1, 0, 1, 0, 1, 0};
    localparam int PHASE_IDLE  [NUM_PHASES] = '{0, 59, 0, 35, 0, 35, 59};
    localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 59, 35, 59, 35, 0};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{6, 6, 60, 4, 4, 6, 6};

    // One result as the block presents it
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              done;
        logic              fin;
    } scan_result_t;

    // One row of the directed script: a register write or an item, with an
    // optional typed-in expectation (none, or exactly one result)
    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    value;
        logic                 ends;
        logic                 typed;
        logic                 has_res;
        scan_result_t         res;
    } script_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    logic                  full;
    logic [BYTE_W-1:0]     data_byte;
    logic                  blob_end;
    logic                  empty;
    logic                  pop;
    logic [CHAR_W-1:0]     out_char;
    logic                  string_done;
    logic                  final_of_run;

    // Typed expectation that travels with the item on the bus
    logic         row_typed;
    logic         row_has_res;
    scan_result_t row_res;

    // Predictor state
    logic [MIN_LEN_W-1:0] min_len_reg;
    logic                 wide_reg;
    logic [CHAR_W-1:0]    held_text [MAX_LEN-1];
    int                   run_count;
    logic [BYTE_W-1:0]    low_half;
    logic                 want_high;

    scan_result_t pending_results [$];

    int  mismatch_count;
    int  results_seen;
    int  bytes_offered;
    int  cycle_count;
    int  prior_count;
    int  send_idle_pct;
    int  pop_stall_pct;
    int  hold_count;
    bit  hold_off_req;

    script_row_t script [SCRIPT_ROWS];

    printable_string_extractor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .blob_end     (blob_end),
        .empty        (empty),
        .pop          (pop),
        .out_char     (out_char),
        .string_done  (string_done),
        .final_of_run (final_of_run)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp the programmed minimum into 1..MAX_LEN
    function automatic int active_min_len();
        if (min_len_reg == 0)
            return 1;
        if (min_len_reg > MAX_LEN)
            return MAX_LEN;
        return int'(min_len_reg);
    endfunction

    function automatic bit in_text_range(input logic [BYTE_W-1:0] b);
        return (b >= CHAR_LO) && (b < CHAR_END);
    endfunction

    function automatic void add_result(input logic [CHAR_W-1:0] ch, input logic done);
        scan_result_t r;
        r.ch   = ch;
        r.done = done;
        r.fin  = 1'b0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Hold a character back, or release the held ones with it once the run
    // is long enough; a released run passes characters straight through
    function automatic void hold_or_release(input logic [CHAR_W-1:0] ch);
        int need;
        need = active_min_len();
        if (run_count >= MAX_LEN)
        begin
            add_result(ch, 1'b0);
            return;
        end
        if (run_count + 1 >= need)
        begin
            for (int k = 0; k < run_count && k < MAX_LEN - 1; k++)
                add_result(held_text[k], 1'b0);
            add_result(ch, 1'b0);
            run_count = MAX_LEN;
            return;
        end
        if (run_count < MAX_LEN - 1)
            held_text[run_count] = ch;
        run_count++;
    endfunction

    // A break closes a released run with a marker; held text is dropped
    function automatic void close_run();
        if (run_count >= MAX_LEN)
            add_result('0, 1'b1);
        run_count = 0;
    endfunction

    function automatic void scan_byte(input logic [BYTE_W-1:0] b, input logic ends);
        int first;
        first = pending_results.size();
        if (!wide_reg)
        begin
            want_high = 1'b0;
            if (in_text_range(b))
                hold_or_release(b[CHAR_W-1:0]);
            else
                close_run();
        end
        else if (!want_high)
        begin
            low_half  = b;
            want_high = 1'b1;
        end
        else
        begin
            if (b == 8'h00 && in_text_range(low_half))
                hold_or_release(low_half[CHAR_W-1:0]);
            else
                close_run();
            want_high = 1'b0;
        end
        if (ends)
        begin
            close_run();
            want_high = 1'b0;
        end
        if (pending_results.size() > first)
            pending_results[pending_results.size() - 1].fin = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s of result %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: check popped results, track register writes, predict on
    // every accepted item. All values are those in place before the edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    // Result with nothing expected
                    report_mismatch("presence", 1, 0);
                end
                else
                begin
                    if (out_char != pending_results[0].ch)
                        report_mismatch("out_char", out_char, pending_results[0].ch);
                    if (string_done != pending_results[0].done)
                        report_mismatch("string_done", string_done, pending_results[0].done);
                    if (final_of_run != pending_results[0].fin)
                        report_mismatch("final_of_run", final_of_run, pending_results[0].fin);
                    void'(pending_results.pop_front());
                end
                results_seen++;
            end

            if (cfg_we)
            begin
                if (cfg_index == REG_MIN_LEN)
                    min_len_reg = cfg_data;
                else if (cfg_index == REG_WIDE_MODE)
                    wide_reg = cfg_data[0];
            end

            if (push && !full)
            begin
                prior_count = pending_results.size();
                scan_byte(data_byte, blob_end);
                // A typed row replaces what the predictor worked out, while the
                // predictor state still advances
                if (row_typed)
                begin
                    while (pending_results.size() > prior_count)
                        void'(pending_results.pop_back());
                    if (row_has_res)
                        pending_results.insert(pending_results.size(), row_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge clk);
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Watchdog: a hang or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("printable_string_extractor_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item and hold it until accepted; push stays high on return
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic ends,
                             input logic typed = 1'b0, input logic has_res = 1'b0,
                             input scan_result_t res = '0);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        data_byte   <= b;
        blob_end    <= ends;
        row_typed   <= typed;
        row_has_res <= has_res;
        row_res     <= res;
        do
            @(posedge clk);
        while (full);
        bytes_offered++;
    endtask

    // Drop push and wait until every predicted result has been popped; the
    // first edge lets the monitor take in the last accepted item
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write a register with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        // Let the predictor pick up the new value
        @(posedge clk);
    endtask

    // One printable character in the current mode
    task automatic send_text_char(input logic [BYTE_W-1:0] c, input logic ends);
        if (wide_reg)
        begin
            send_item(c, 1'b0);
            send_item(8'h00, ends);
        end
        else
            send_item(c, ends);
    endtask

    function automatic logic [BYTE_W-1:0] pick_control_byte();
        if ($urandom_range(1))
            return BYTE_W'($urandom_range(8'h00, 8'h1F));
        return BYTE_W'($urandom_range(8'h7F, 8'hFF));
    endfunction

    // One break in the current mode: bad byte, or a pair with a bad half
    task automatic send_break(input logic ends);
        if (!wide_reg)
            send_item(pick_control_byte(), ends);
        else if ($urandom_range(1))
        begin
            send_item(pick_control_byte(), 1'b0);
            send_item(8'h00, ends);
        end
        else
        begin
            send_item(BYTE_W'($urandom_range(8'h20, 8'h7E)), 1'b0);
            send_item(BYTE_W'($urandom_range(1, 255)), ends);
        end
    endtask

    // One blob: mostly runs of text around the minimum length split by
    // breaks, sometimes plain noise with stray blob ends
    task automatic send_blob();
        int runs;
        int len;
        if ($urandom_range(99) < 20)
        begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
                send_item(BYTE_W'($urandom_range(0, 255)), $urandom_range(7) == 0);
            return;
        end
        runs = $urandom_range(1, 2);
        for (int r = 0; r < runs; r++)
        begin
            len = $urandom_range(0, active_min_len() + 2);
            for (int k = 0; k < len; k++)
                send_text_char(BYTE_W'($urandom_range(8'h20, 8'h7E)), 1'b0);
            if (r < runs - 1)
                send_break(1'b0);
        end
        // The closing byte carries blob_end: text, a break, or a lone byte
        // (a trailing odd byte in wide mode)
        case ($urandom_range(2))
            0: send_text_char(BYTE_W'($urandom_range(8'h20, 8'h7E)), 1'b1);
            1: send_break(1'b1);
            default: send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
        endcase
    endtask

    // Script row builders
    function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [BYTE_W-1:0] val);
        script_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = val;
        return row;
    endfunction

    function automatic script_row_t item_row(input logic [BYTE_W-1:0] b, input logic ends);
        script_row_t row;
        row       = '0;
        row.value = b;
        row.ends  = ends;
        return row;
    endfunction

    function automatic script_row_t quiet_row(input logic [BYTE_W-1:0] b, input logic ends);
        script_row_t row;
        row       = item_row(b, ends);
        row.typed = 1'b1;
        return row;
    endfunction

    function automatic script_row_t one_row(input logic [BYTE_W-1:0] b, input logic ends,
                                            input logic [CHAR_W-1:0] ch, input logic done);
        script_row_t row;
        row          = quiet_row(b, ends);
        row.has_res  = 1'b1;
        row.res.ch   = ch;
        row.res.done = done;
        row.res.fin  = 1'b1;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int start;
        bit paused;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_MIN_LEN;
        cfg_data      = '0;
        push          = 1'b0;
        data_byte     = '0;
        blob_end      = 1'b0;
        row_typed     = 1'b0;
        row_has_res   = 1'b0;
        row_res       = '0;
        min_len_reg   = MIN_LEN_RESET;
        wide_reg      = 1'b0;
        run_count     = 0;
        low_half      = '0;
        want_high     = 1'b0;
        mismatch_count = 0;
        results_seen  = 0;
        bytes_offered = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_off_req  = 1'b0;

        script = '{
            // After reset: minimum 6, ASCII. Held text, then discarded by a break
            quiet_row(8'h41, 1'b0),
            quiet_row(8'h00, 1'b0),
            // A minimum of zero acts as one: every character releases at once
            cfg_row(REG_MIN_LEN, 8'd0),
            one_row(8'h20, 1'b0, 7'h20, 1'b0),
            one_row(8'h7E, 1'b0, 7'h7E, 1'b0),
            // Break after a released run gives one end marker
            one_row(8'h7F, 1'b0, 7'h00, 1'b1),
            quiet_row(8'h1F, 1'b1),
            // Minimum above range acts as the maximum; lower it mid-run so the
            // next character releases everything held
            cfg_row(REG_MIN_LEN, 8'd31),
            item_row(8'h61, 1'b0),
            item_row(8'h62, 1'b0),
            item_row(8'h63, 1'b0),
            cfg_row(REG_MIN_LEN, 8'd2),
            item_row(8'h64, 1'b0),
            item_row(8'hFF, 1'b1),
            // Wide mode pairs; switch to ASCII mid-blob with a low byte pending
            cfg_row(REG_MIN_LEN, 8'd3),
            cfg_row(REG_WIDE_MODE, 8'd1),
            item_row(8'h48, 1'b0),
            item_row(8'h00, 1'b0),
            item_row(8'h69, 1'b0),
            item_row(8'h00, 1'b0),
            item_row(8'h78, 1'b0),
            cfg_row(REG_WIDE_MODE, 8'd0),
            item_row(8'h21, 1'b0),
            item_row(8'h80, 1'b1),
            // Wide mode: nonzero high byte breaks; trailing odd byte is dropped
            cfg_row(REG_WIDE_MODE, 8'd1),
            item_row(8'h41, 1'b0),
            item_row(8'h00, 1'b0),
            item_row(8'h43, 1'b0),
            item_row(8'h01, 1'b0),
            item_row(8'h42, 1'b1),
            item_row(8'h20, 1'b0),
            item_row(8'h00, 1'b1)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script
        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            if (script[i].is_cfg)
                write_reg(script[i].idx, script[i].value[CFG_DATA_W-1:0]);
            else
                send_item(script[i].value, script[i].ends, script[i].typed,
                          script[i].has_res, script[i].res);
        end

        // Random phases, each with its own settings and idle pattern
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_MIN_LEN, CFG_DATA_W'(PHASE_MIN[p]));
            write_reg(REG_WIDE_MODE, CFG_DATA_W'(PHASE_WIDE[p]));
            send_idle_pct = PHASE_IDLE[p];
            pop_stall_pct = PHASE_STALL[p];
            // Fill the block while the receiver holds off
            if (p == PRESSURE_PHASE)
                hold_off_req = 1'b1;
            start  = bytes_offered;
            paused = 1'b0;
            while (bytes_offered - start < PHASE_ITEMS[p])
            begin
                // Halfway through, stop and let every result come out
                if (p == PAUSE_PHASE && !paused
                    && bytes_offered - start >= PHASE_ITEMS[p] / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                send_blob();
            end
        end

        // Let the tail drain with no stalls, then allow stray results to show
        pop_stall_pct = 0;
        drain();
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0)
            $display("printable_string_extractor_test: PASS");
        else
            $display("printable_string_extractor_test: FAIL");
        $finish;
    end

endmodule
